[src/tmcw_pkg.sv]
package tmcw_pkg;

    localparam int COLUMNS_DEFAULT     = 80;
    localparam int ROWS_DEFAULT        = 25;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam logic [CHAR_W-1:0] SPACE_GLYPH   = 8'h20;
    localparam logic [CHAR_W-1:0] NEWLINE_GLYPH = 8'h0A;
    localparam logic [CHAR_W-1:0] CLEAR_ATTR    = 8'h07;
    localparam logic [CHAR_W-1:0] BLANK_ATTR    = 8'h00;

    typedef enum logic [2:0] {
        OP_PUT       = 3'd0,
        OP_BACKSPACE = 3'd1,
        OP_CLEAR     = 3'd2,
        OP_POKE      = 3'd3,
        OP_PEEK      = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        K_NOP,
        K_PUT,
        K_NEWLINE,
        K_BACKSPACE,
        K_CLEAR,
        K_POKE,
        K_PEEK,
        K_OFF_SCREEN
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [CHAR_W-1:0]  glyph;
        logic [CHAR_W-1:0]  attr;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]   cursor_position;
        logic [CHAR_W-1:0]  read_glyph;
        logic [CHAR_W-1:0]  read_attribute;
        logic               out_of_range;
    } res_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_CLEAR,
        ST_DONE
    } state_t;

endpackage

[src/tmcw_fifo.sv]
module tmcw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tmcw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/tmcw_front.sv]
module tmcw_front #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
    input  logic                       push,
    output logic                       full,
    input  logic [2:0]                 opcode,
    input  logic [tmcw_pkg::CHAR_W-1:0] glyph,
    input  logic [3:0]                 fore_color,
    input  logic [3:0]                 back_color,
    input  logic [tmcw_pkg::COL_W-1:0] column,
    input  logic [tmcw_pkg::ROW_W-1:0] row,
    input  logic                       cmd_full,
    input  logic                       init_busy,
    output logic                       cmd_push,
    output tmcw_pkg::cmd_t             cmd
);

    logic in_range;

    assign full     = cmd_full || init_busy;
    assign cmd_push = push && !full;
    assign in_range = (column < tmcw_pkg::COL_W'(COLUMNS)) && (row < tmcw_pkg::ROW_W'(ROWS));

    always_comb
    begin
        cmd.glyph  = glyph;
        cmd.attr   = {back_color, fore_color};
        cmd.column = column;
        cmd.row    = row;
        case (tmcw_pkg::opcode_t'(opcode))
            tmcw_pkg::OP_PUT:
            begin
                cmd.kind = (glyph == tmcw_pkg::NEWLINE_GLYPH) ? tmcw_pkg::K_NEWLINE
                                                              : tmcw_pkg::K_PUT;
            end
            tmcw_pkg::OP_BACKSPACE: cmd.kind = tmcw_pkg::K_BACKSPACE;
            tmcw_pkg::OP_CLEAR:     cmd.kind = tmcw_pkg::K_CLEAR;
            tmcw_pkg::OP_POKE:
            begin
                cmd.kind = in_range ? tmcw_pkg::K_POKE : tmcw_pkg::K_OFF_SCREEN;
            end
            tmcw_pkg::OP_PEEK:
            begin
                cmd.kind = in_range ? tmcw_pkg::K_PEEK : tmcw_pkg::K_OFF_SCREEN;
            end
            default:                cmd.kind = tmcw_pkg::K_NOP;
        endcase
    end

endmodule

[src/tmcw_back.sv]
module tmcw_back #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = tmcw_pkg::ROWS_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  tmcw_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output tmcw_pkg::res_t res,
    output logic           init_busy
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int COL_W      = tmcw_pkg::COL_W;
    localparam int ROW_W      = tmcw_pkg::ROW_W;
    localparam int CHAR_W     = tmcw_pkg::CHAR_W;
    localparam int WIDE_W     = COL_W + ROW_W + 1;

    logic [tmcw_pkg::CELL_W-1:0] cells_mem [CELL_COUNT];
    logic [tmcw_pkg::CELL_W-1:0] rdata_reg;

    tmcw_pkg::state_t  state_reg, state_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [AW-1:0]     sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]     sweep_last_reg, sweep_last_next;
    logic [CHAR_W-1:0] rd_glyph_reg, rd_glyph_next;
    logic [CHAR_W-1:0] rd_attr_reg, rd_attr_next;
    logic              oor_reg, oor_next;

    logic [COL_W-1:0]  bs_col;
    logic [ROW_W-1:0]  bs_row;
    logic [COL_W-1:0]  a_col;
    logic [ROW_W-1:0]  a_row;
    logic [ROW_W:0]    phys_sum;
    logic [ROW_W-1:0]  phys_row;
    logic [AW-1:0]     cell_addr;
    logic [AW-1:0]     scroll_base;
    logic [WIDE_W-1:0] pos_full;

    logic                        mem_we;
    logic                        mem_re;
    logic [AW-1:0]               mem_waddr;
    logic [tmcw_pkg::CELL_W-1:0] mem_wdata;
    logic                        advance_line;

    assign init_busy = (state_reg == tmcw_pkg::ST_INIT);

    assign pos_full = WIDE_W'(cur_row_reg) * WIDE_W'(COLUMNS) + WIDE_W'(cur_col_reg);
    assign res.cursor_position = pos_full[tmcw_pkg::POS_W-1:0];
    assign res.read_glyph      = rd_glyph_reg;
    assign res.read_attribute  = rd_attr_reg;
    assign res.out_of_range    = oor_reg;

    always_comb
    begin
        bs_col = cur_col_reg;
        bs_row = cur_row_reg;
        if (cur_col_reg == '0)
        begin
            if (cur_row_reg != '0)
            begin
                bs_row = cur_row_reg - 1'b1;
                bs_col = COL_W'(COLUMNS - 1);
            end
        end
        else
        begin
            bs_col = cur_col_reg - 1'b1;
        end
    end

    always_comb
    begin
        case (cmd.kind)
            tmcw_pkg::K_PUT:
            begin
                a_col = cur_col_reg;
                a_row = cur_row_reg;
            end
            tmcw_pkg::K_BACKSPACE:
            begin
                a_col = bs_col;
                a_row = bs_row;
            end
            default:
            begin
                a_col = cmd.column;
                a_row = cmd.row;
            end
        endcase
        phys_sum    = {1'b0, a_row} + {1'b0, top_reg};
        phys_row    = (phys_sum >= (ROW_W + 1)'(ROWS)) ? ROW_W'(phys_sum - (ROW_W + 1)'(ROWS))
                                                       : phys_sum[ROW_W-1:0];
        cell_addr   = AW'(phys_row) * AW'(COLUMNS) + AW'(a_col);
        scroll_base = AW'(top_reg) * AW'(COLUMNS);
    end

    always_comb
    begin
        state_next      = state_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        rd_glyph_next   = rd_glyph_reg;
        rd_attr_next    = rd_attr_reg;
        oor_next        = oor_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = sweep_addr_reg;
        mem_wdata       = {tmcw_pkg::CLEAR_ATTR, tmcw_pkg::SPACE_GLYPH};
        advance_line    = 1'b0;

        case (state_reg)
            tmcw_pkg::ST_INIT:
            begin
                mem_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            tmcw_pkg::ST_IDLE:
            begin
                if (!cmd_empty && !res_full)
                begin
                    cmd_pop       = 1'b1;
                    rd_glyph_next = '0;
                    rd_attr_next  = '0;
                    oor_next      = 1'b0;
                    state_next    = tmcw_pkg::ST_DONE;
                    mem_waddr     = cell_addr;
                    case (cmd.kind)
                        tmcw_pkg::K_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {cmd.attr, cmd.glyph};
                            if (cur_col_reg == COL_W'(COLUMNS - 1))
                            begin
                                advance_line = 1'b1;
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        tmcw_pkg::K_NEWLINE:
                        begin
                            advance_line = 1'b1;
                        end
                        tmcw_pkg::K_BACKSPACE:
                        begin
                            cur_col_next = bs_col;
                            cur_row_next = bs_row;
                            mem_we       = 1'b1;
                            mem_wdata    = {tmcw_pkg::BLANK_ATTR, tmcw_pkg::SPACE_GLYPH};
                        end
                        tmcw_pkg::K_CLEAR:
                        begin
                            cur_col_next    = '0;
                            cur_row_next    = '0;
                            top_next        = '0;
                            sweep_addr_next = '0;
                            sweep_last_next = AW'(CELL_COUNT - 1);
                            state_next      = tmcw_pkg::ST_CLEAR;
                        end
                        tmcw_pkg::K_POKE:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {cmd.attr, cmd.glyph};
                        end
                        tmcw_pkg::K_PEEK:
                        begin
                            mem_re     = 1'b1;
                            state_next = tmcw_pkg::ST_READ;
                        end
                        tmcw_pkg::K_OFF_SCREEN:
                        begin
                            oor_next = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (advance_line)
                    begin
                        cur_col_next = '0;
                        if (cur_row_reg == ROW_W'(ROWS - 1))
                        begin
                            sweep_addr_next = scroll_base;
                            sweep_last_next = scroll_base + AW'(COLUMNS - 1);
                            state_next      = tmcw_pkg::ST_SCROLL;
                        end
                        else
                        begin
                            cur_row_next = cur_row_reg + 1'b1;
                        end
                    end
                end
            end

            tmcw_pkg::ST_READ:
            begin
                rd_glyph_next = rdata_reg[CHAR_W-1:0];
                rd_attr_next  = rdata_reg[tmcw_pkg::CELL_W-1:CHAR_W];
                state_next    = tmcw_pkg::ST_DONE;
            end

            tmcw_pkg::ST_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_wdata = {tmcw_pkg::BLANK_ATTR, tmcw_pkg::SPACE_GLYPH};
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    top_next   = (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                    state_next = tmcw_pkg::ST_DONE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            tmcw_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = tmcw_pkg::ST_DONE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            tmcw_pkg::ST_DONE:
            begin
                res_push   = 1'b1;
                state_next = tmcw_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tmcw_pkg::ST_INIT;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_last_reg <= AW'(CELL_COUNT - 1);
            rd_glyph_reg   <= '0;
            rd_attr_reg    <= '0;
            oor_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            rd_glyph_reg   <= rd_glyph_next;
            rd_attr_reg    <= rd_attr_next;
            oor_reg        <= oor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cells_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= cells_mem[cell_addr];
        end
    end

endmodule

[src/text_mode_console_writer_core.sv]
// Text-mode console engine with a COLUMNS x ROWS store of 16-bit cells (attribute
// in 15:8, glyph in 7:0) and a cursor. Commands enter through a push/full queue and
// each one gives exactly one result through an empty/pop queue, in order. After
// reset the cell memory is filled with spaces of attribute 0x07, one cell a cycle,
// and full stays high until the fill is done. The cell memory has one write port
// and one registered read port, and the executing side handles one command at a
// time. Each command ends in a done state that pushes its result; a cell read
// passes a read state first, a line feed from the last row first blanks the new
// bottom row one cell a cycle, and a clear refills all cells with 0x07 spaces.
// Scrolling rotates the displayed top row instead of moving cells. A short
// command queue lets new commands be taken while one is executing.
module text_mode_console_writer_core #(
    parameter int COLUMNS     = tmcw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS        = tmcw_pkg::ROWS_DEFAULT,
    parameter int QUEUE_DEPTH = tmcw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [2:0]                   opcode,
    input  logic [tmcw_pkg::CHAR_W-1:0]  glyph,
    input  logic [3:0]                   fore_color,
    input  logic [3:0]                   back_color,
    input  logic [tmcw_pkg::COL_W-1:0]   column,
    input  logic [tmcw_pkg::ROW_W-1:0]   row,
    output logic                         empty,
    input  logic                         pop,
    output logic [tmcw_pkg::POS_W-1:0]   cursor_position,
    output logic [tmcw_pkg::CHAR_W-1:0]  read_glyph,
    output logic [tmcw_pkg::CHAR_W-1:0]  read_attribute,
    output logic                         out_of_range
);

    localparam int CMD_W = $bits(tmcw_pkg::cmd_t);
    localparam int RES_W = $bits(tmcw_pkg::res_t);

    tmcw_pkg::cmd_t   front_cmd;
    tmcw_pkg::cmd_t   back_cmd;
    tmcw_pkg::res_t   back_res;
    tmcw_pkg::res_t   out_res;
    logic [CMD_W-1:0] cmd_q_data;
    logic [RES_W-1:0] res_q_data;
    logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic             res_push, res_full;
    logic             init_busy;

    tmcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .glyph      (glyph),
        .fore_color (fore_color),
        .back_color (back_color),
        .column     (column),
        .row        (row),
        .cmd_full   (cmd_full),
        .init_busy  (init_busy),
        .cmd_push   (cmd_push),
        .cmd        (front_cmd)
    );

    tmcw_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (front_cmd),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_q_data),
        .empty     (cmd_empty)
    );

    assign back_cmd = tmcw_pkg::cmd_t'(cmd_q_data);

    tmcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (back_cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (back_res),
        .init_busy (init_busy)
    );

    tmcw_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (back_res),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (res_q_data),
        .empty     (empty)
    );

    assign out_res         = tmcw_pkg::res_t'(res_q_data);
    assign cursor_position = out_res.cursor_position;
    assign read_glyph      = out_res.read_glyph;
    assign read_attribute  = out_res.read_attribute;
    assign out_of_range    = out_res.out_of_range;

endmodule
